// ----- src/bspe_pkg.sv -----
// Package for the B-spline curve point evaluator.
// Holds function codes, register indexes, fixed widths and the divider request type.
// No dependencies.
package bspe_pkg;

    // Function codes carried by an input item.
    localparam logic [1:0] FUNC_KNOT  = 2'd0;
    localparam logic [1:0] FUNC_POINT = 2'd1;
    localparam logic [1:0] FUNC_EVAL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_KNOTS  = 2'd1;

    // Fixed widths.
    localparam int COORD_W = 32;
    localparam int POINT_W = 3 * COORD_W;
    localparam int IDX_W   = 9;
    localparam int DEG_W   = 4;
    localparam int ALPHA_W = 17;
    localparam int QUO_W   = 16;

    // Alpha equal to one in Q16.
    localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } div_req_t;

endpackage

// ----- src/bspe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bspe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/bspe_div.sv -----
// Restoring divider that produces the 16 fraction bits of num / den, one bit a cycle.
// Depends on bspe_pkg. The numerator is positive and below the denominator.
module bspe_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bspe_pkg::div_req_t              req,
    output logic [bspe_pkg::QUO_W-1:0]      quo,
    output logic                            done
);

    logic [33:0]               rem_reg;
    logic [32:0]               den_reg;
    logic [bspe_pkg::QUO_W-1:0] quo_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [33:0]               rem_dbl;
    logic                      fits;

    // One trial subtraction per cycle.
    assign rem_dbl = {rem_reg[32:0], 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= {1'b0, req.num};
                den_reg  <= req.den;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;
                quo_reg <= {quo_reg[bspe_pkg::QUO_W-2:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(bspe_pkg::QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

    // A result only follows a running division.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// ----- src/bspe_mul.sv -----
// Shared multiplier: unsigned Q16 weight times a signed Q16.16 coordinate.
// Depends on bspe_pkg. The product is registered.
module bspe_mul (
    input  logic                              aclk,
    input  logic [bspe_pkg::ALPHA_W-1:0]      weight,
    input  logic signed [bspe_pkg::COORD_W-1:0] coord,
    output logic signed [49:0]                prod
);

    logic signed [17:0] weight_s;
    logic signed [49:0] prod_next;

    // Weight is never negative, so it takes a zero sign bit.
    assign weight_s  = $signed({1'b0, weight});
    assign prod_next = weight_s * coord;

    always_ff @(posedge aclk) begin
        prod <= prod_next;
    end

endmodule

// ----- src/bspline_curve_point_eval_top.sv -----
// Top level of the B-spline curve point evaluator with its sequencer.
// Depends on bspe_pkg, bspe_ram, bspe_div and bspe_mul.
//
// Use: an item on the s_ channel writes one knot (func 0), writes one control
// point (func 1) or evaluates the curve at s_param_u (func 2). Writes give no
// result item; an evaluation gives one item on the m_ channel with the point
// and in_range. Registers spline_degree and knot_count are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce it. A write item
// leaves the block idle. An evaluation tries the spans of the search in turn,
// copies the degree+1 control points of the span, runs degree*(degree+1)/2
// blends, each with a divide when one is needed and a plain copy when the
// knot interval is empty, and then finishes. Its speed is set by the one
// shared divider, the one shared multiplier used six times per blend, and
// the single read port of each store.
// The block takes no new item while an evaluation runs. The result sits in an
// output register; the block accepts further items while it waits, but a
// later evaluation holds before delivery until the receiver takes it.
// Reset restores degree 3 and knot count 9; the stores keep no reset value.
module bspline_curve_point_eval_top #(
    parameter int MAX_KNOTS  = 32,
    parameter int MAX_DEGREE = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [4:0]          s_slot,
    input  logic signed [31:0]  s_knot_value,
    input  logic signed [31:0]  s_point_x,
    input  logic signed [31:0]  s_point_y,
    input  logic signed [31:0]  s_point_z,
    input  logic signed [31:0]  s_param_u,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_curve_x,
    output logic signed [31:0]  m_curve_y,
    output logic signed [31:0]  m_curve_z,
    output logic                m_in_range
);

    localparam int KA = $clog2(MAX_KNOTS);
    localparam int WA = $clog2(MAX_DEGREE + 1);
    localparam int IW = bspe_pkg::IDX_W;
    localparam int DW = bspe_pkg::DEG_W;
    localparam int PW = bspe_pkg::POINT_W;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_SRD   = 19'h00002,
        S_SRD2  = 19'h00004,
        S_SCHK  = 19'h00008,
        S_CRD   = 19'h00010,
        S_CWR   = 19'h00020,
        S_KLO   = 19'h00040,
        S_KHI   = 19'h00080,
        S_KCAP  = 19'h00100,
        S_DIV   = 19'h00200,
        S_RPREV = 19'h00400,
        S_RCUR  = 19'h00800,
        S_CAPC  = 19'h01000,
        S_MUL   = 19'h02000,
        S_ACC   = 19'h04000,
        S_WR    = 19'h08000,
        S_FRD   = 19'h10000,
        S_FCAP  = 19'h20000,
        S_DONE  = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]                  spline_degree_reg;
    logic [5:0]                  knot_count_reg;
    logic signed [31:0]          u_reg;
    logic [DW-1:0]               deg_reg, k_reg, r_reg, j_reg;
    logic signed [9:0]           end_reg;
    logic [IW-1:0]               i_reg, span_reg;
    logic signed [31:0]          knot_i_reg, lo_reg;
    logic [bspe_pkg::ALPHA_W-1:0] alpha_reg;
    logic                        copy_reg;
    logic [PW-1:0]               prev_reg, cur_reg, res_reg;
    logic [2:0]                  cnt_reg;
    logic signed [34:0]          acc_reg;
    logic                        rng_reg;
    logic                        m_valid_reg;
    logic [PW-1:0]               m_data_reg;
    logic                        m_rng_reg;

    // Effective degree, knot count and search end from the registers.
    logic [3:0]        deg_wide;
    logic [8:0]        kc_wide;
    logic signed [9:0] end_eff;
    logic [DW-1:0]     deg_eff;
    assign deg_wide = (4'(spline_degree_reg) > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE)
                                                             : 4'(spline_degree_reg);
    assign kc_wide  = (9'(knot_count_reg) > 9'(MAX_KNOTS)) ? 9'(MAX_KNOTS)
                                                         : 9'(knot_count_reg);
    assign deg_eff  = DW'(deg_wide);
    assign end_eff  = $signed({1'b0, kc_wide}) - $signed(10'(deg_wide)) - 10'sd2;

    logic s_acc;
    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid && s_ready;

    // Store addresses.
    logic [IW-1:0] i_inc, lo_idx, hi_idx, src_idx;
    logic [DW-1:0] j_dec;
    assign i_inc   = i_reg + 9'd1;
    assign lo_idx  = span_reg + 9'(j_reg) - 9'(deg_reg);
    assign hi_idx  = span_reg + 9'(j_reg) + 9'd1 - 9'(r_reg);
    assign src_idx = span_reg + 9'(k_reg) - 9'(deg_reg);
    assign j_dec   = j_reg - 4'd1;

    logic              knot_we, ctrl_we, work_we;
    logic [KA-1:0]     knot_raddr, ctrl_raddr, wr_slot;
    logic [WA-1:0]     work_waddr, work_raddr;
    logic [PW-1:0]     work_wdata, ctrl_rdata, work_rdata;
    logic signed [31:0] knot_rdata;

    assign wr_slot = KA'(s_slot);
    assign knot_we = s_acc && (s_func == bspe_pkg::FUNC_KNOT) && (9'(s_slot) < 9'(MAX_KNOTS));
    assign ctrl_we = s_acc && (s_func == bspe_pkg::FUNC_POINT) && (9'(s_slot) < 9'(MAX_KNOTS));

    always_comb begin
        case (state_reg)
            S_SRD2:  knot_raddr = i_inc[KA-1:0];
            S_KLO:   knot_raddr = lo_idx[KA-1:0];
            S_KHI:   knot_raddr = hi_idx[KA-1:0];
            default: knot_raddr = i_reg[KA-1:0];
        endcase
    end

    assign ctrl_raddr = src_idx[KA-1:0];

    always_comb begin
        case (state_reg)
            S_RPREV: work_raddr = j_dec[WA-1:0];
            S_FRD:   work_raddr = deg_reg[WA-1:0];
            default: work_raddr = j_reg[WA-1:0];
        endcase
    end

    assign work_we    = (state_reg == S_CWR) || (state_reg == S_WR);
    assign work_waddr = (state_reg == S_CWR) ? k_reg[WA-1:0] : j_reg[WA-1:0];
    assign work_wdata = (state_reg == S_CWR) ? ctrl_rdata : res_reg;

    bspe_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
        .aclk(aclk), .we(knot_we), .waddr(wr_slot), .wdata(s_knot_value),
        .raddr(knot_raddr), .rdata(knot_rdata)
    );

    bspe_ram #(.WIDTH(PW), .DEPTH(MAX_KNOTS)) u_ctrl_ram (
        .aclk(aclk), .we(ctrl_we), .waddr(wr_slot),
        .wdata({s_point_z, s_point_y, s_point_x}),
        .raddr(ctrl_raddr), .rdata(ctrl_rdata)
    );

    bspe_ram #(.WIDTH(PW), .DEPTH(MAX_DEGREE + 1)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    // Knot differences for the current blend.
    logic signed [32:0] kdiv, knum;
    assign kdiv = {knot_rdata[31], knot_rdata} - {lo_reg[31], lo_reg};
    assign knum = {u_reg[31], u_reg} - {lo_reg[31], lo_reg};

    logic need_div;
    assign need_div = (kdiv > 33'sd0) && (knum > 33'sd0) && (knum < kdiv);

    bspe_pkg::div_req_t        div_req;
    logic [bspe_pkg::QUO_W-1:0] div_quo;
    logic                      div_done;
    assign div_req.start = (state_reg == S_KCAP) && need_div;
    assign div_req.num   = knum;
    assign div_req.den   = kdiv;

    bspe_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .quo(div_quo), .done(div_done)
    );

    // Shared multiplier: even steps weigh the previous point, odd the current one.
    logic [bspe_pkg::ALPHA_W-1:0] mul_weight;
    logic signed [31:0]           mul_coord;
    logic signed [49:0]           mul_prod;
    logic [1:0]                   coord_sel;
    logic [PW-1:0]                mul_src;
    assign coord_sel  = cnt_reg[2:1];
    assign mul_weight = cnt_reg[0] ? alpha_reg : (bspe_pkg::ONE_Q16 - alpha_reg);
    assign mul_src    = cnt_reg[0] ? cur_reg : prev_reg;

    always_comb begin
        case (coord_sel)
            2'd1:    mul_coord = mul_src[63:32];
            2'd2:    mul_coord = mul_src[95:64];
            default: mul_coord = mul_src[31:0];
        endcase
    end

    bspe_mul u_mul (.aclk(aclk), .weight(mul_weight), .coord(mul_coord), .prod(mul_prod));

    // Floor by 2^16, sum of both terms, saturation to 32 bits.
    logic signed [33:0] prod_sh;
    logic signed [34:0] sum;
    logic signed [31:0] sat_sum;
    assign prod_sh = mul_prod[49:16];
    assign sum     = acc_reg + 35'(prod_sh);
    always_comb begin
        if (sum > 35'sd2147483647) begin
            sat_sum = 32'sh7fffffff;
        end else if (sum < -35'sd2147483648) begin
            sat_sum = 32'sh80000000;
        end else begin
            sat_sum = sum[31:0];
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_func == bspe_pkg::FUNC_EVAL)) begin
                    state_next = ($signed({6'd0, deg_eff}) < end_eff) ? S_SRD : S_DONE;
                end
            end
            S_SRD:  state_next = S_SRD2;
            S_SRD2: state_next = S_SCHK;
            S_SCHK: begin
                if ((knot_i_reg <= u_reg) && (u_reg < knot_rdata)) begin
                    state_next = S_CRD;
                end else if ($signed({1'b0, i_inc}) < end_reg) begin
                    state_next = S_SRD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CRD: state_next = S_CWR;
            S_CWR: begin
                if (k_reg == deg_reg) begin
                    state_next = (deg_reg == '0) ? S_FRD : S_KLO;
                end else begin
                    state_next = S_CRD;
                end
            end
            S_KLO:   state_next = S_KHI;
            S_KHI:   state_next = S_KCAP;
            S_KCAP:  state_next = need_div ? S_DIV : S_RPREV;
            S_DIV:   state_next = div_done ? S_RPREV : S_DIV;
            S_RPREV: state_next = S_RCUR;
            S_RCUR:  state_next = copy_reg ? S_WR : S_CAPC;
            S_CAPC:  state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = (cnt_reg == 3'd5) ? S_WR : S_MUL;
            S_WR: begin
                if ((j_reg == r_reg) && (r_reg == deg_reg)) begin
                    state_next = S_FRD;
                end else begin
                    state_next = S_KLO;
                end
            end
            S_FRD:  state_next = S_FCAP;
            S_FCAP: state_next = S_DONE;
            S_DONE: state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            spline_degree_reg <= 3'd3;
            knot_count_reg    <= 6'd9;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == bspe_pkg::REG_DEGREE)) begin
                spline_degree_reg <= cfg_data[2:0];
            end
            if (cfg_we && (cfg_index == bspe_pkg::REG_KNOTS)) begin
                knot_count_reg <= cfg_data;
            end
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the evaluation.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                u_reg    <= s_param_u;
                deg_reg  <= deg_eff;
                end_reg  <= end_eff;
                i_reg    <= 9'(deg_eff);
                res_reg  <= '0;
                rng_reg  <= 1'b0;
            end
            S_SRD2: knot_i_reg <= knot_rdata;
            S_SCHK: begin
                span_reg <= i_reg;
                i_reg    <= i_inc;
                k_reg    <= '0;
            end
            S_CWR: begin
                k_reg <= k_reg + 4'd1;
                r_reg <= 4'd1;
                j_reg <= deg_reg;
            end
            S_KHI: lo_reg <= knot_rdata;
            S_KCAP: begin
                copy_reg <= !(kdiv > 33'sd0);
                if (knum <= 33'sd0) begin
                    alpha_reg <= '0;
                end else begin
                    alpha_reg <= bspe_pkg::ONE_Q16;
                end
            end
            S_DIV: alpha_reg <= {1'b0, div_quo};
            S_RCUR: begin
                prev_reg <= work_rdata;
                res_reg  <= work_rdata;
                cnt_reg  <= '0;
            end
            S_CAPC: cur_reg <= work_rdata;
            S_ACC: begin
                cnt_reg <= cnt_reg + 3'd1;
                if (!cnt_reg[0]) begin
                    acc_reg <= 35'(prod_sh);
                end else begin
                    case (coord_sel)
                        2'd1:    res_reg[63:32] <= sat_sum;
                        2'd2:    res_reg[95:64] <= sat_sum;
                        default: res_reg[31:0]  <= sat_sum;
                    endcase
                end
            end
            S_WR: begin
                if (j_reg == r_reg) begin
                    r_reg <= r_reg + 4'd1;
                    j_reg <= deg_reg;
                end else begin
                    j_reg <= j_dec;
                end
            end
            S_FCAP: begin
                res_reg <= work_rdata;
                rng_reg <= 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_reg <= res_reg;
                    m_rng_reg  <= rng_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_curve_x  = m_data_reg[31:0];
    assign m_curve_y  = m_data_reg[63:32];
    assign m_curve_z  = m_data_reg[95:64];
    assign m_in_range = m_rng_reg;

    // Exactly one sequencer state is active.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // A point outside every span is reported as the origin.
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_range) |-> ((m_curve_x == 32'sd0) && (m_curve_y == 32'sd0)
                                      && (m_curve_z == 32'sd0)))
        else $error("out-of-range result carries a nonzero point");

    // The blend weight never exceeds one.
    a_alpha_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (alpha_reg <= bspe_pkg::ONE_Q16))
        else $error("blend weight above one");

endmodule

// ----- tb/sv/bspe_result_checker.sv -----
// Checker for the B-spline curve point evaluator: watches both channels and the register port.
// It predicts each evaluation result in Q16.16 and compares it with the delivered item.
// Depends on bspe_pkg.
module bspe_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [4:0]          s_slot,
    input  logic signed [31:0]  s_knot_value,
    input  logic signed [31:0]  s_point_x,
    input  logic signed [31:0]  s_point_y,
    input  logic signed [31:0]  s_point_z,
    input  logic signed [31:0]  s_param_u,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [31:0]  m_curve_x,
    input  logic signed [31:0]  m_curve_y,
    input  logic signed [31:0]  m_curve_z,
    input  logic                m_in_range,
    output int                  fail_count,
    output int                  points_waiting,
    output int                  points_checked,
    output int                  points_outside
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               in_range;
    } curve_pt_t;

    // Shadow copies of the block's registers and stores.
    int unsigned degree_reg;
    int unsigned knot_cnt_reg;
    longint      knot_mem [32];
    longint      cx_mem [32];
    longint      cy_mem [32];
    longint      cz_mem [32];
    curve_pt_t   point_q [$];

    // One weighted blend of two coordinates, products floored, sum saturated.
    function automatic longint blend_coord(longint prev, longint cur, longint alpha);
        longint s;
        s = (((65536 - alpha) * prev) >>> 16) + ((alpha * cur) >>> 16);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    // De Boor evaluation at parameter u with the current shadow state.
    function automatic curve_pt_t curve_point(longint u);
        curve_pt_t res;
        longint    wx [8];
        longint    wy [8];
        longint    wz [8];
        longint    lo, dv, num, alpha;
        int        deg, kc, last, span;
        deg = (degree_reg > 7) ? 7 : int'(degree_reg);
        kc = (knot_cnt_reg > 32) ? 32 : int'(knot_cnt_reg);
        last = kc - deg - 2;
        span = -1;
        for (int i = deg; i < last; i++) begin
            if (span < 0 && knot_mem[i] <= u && u < knot_mem[i+1]) span = i;
        end
        res = '0;
        if (span < 0) return res;
        for (int k = 0; k <= deg; k++) begin
            wx[k] = cx_mem[k + span - deg];
            wy[k] = cy_mem[k + span - deg];
            wz[k] = cz_mem[k + span - deg];
        end
        for (int r = 1; r <= deg; r++) begin
            for (int j = deg; j >= r; j--) begin
                lo = knot_mem[j + span - deg];
                dv = knot_mem[j + span + 1 - r] - lo;
                if (dv > 0) begin
                    num = u - lo;
                    if (num <= 0) alpha = 0;
                    else if (num >= dv) alpha = 65536;
                    else alpha = (num * 65536) / dv;
                    wx[j] = blend_coord(wx[j-1], wx[j], alpha);
                    wy[j] = blend_coord(wy[j-1], wy[j], alpha);
                    wz[j] = blend_coord(wz[j-1], wz[j], alpha);
                end else begin
                    wx[j] = wx[j-1];
                    wy[j] = wy[j-1];
                    wz[j] = wz[j-1];
                end
            end
        end
        res.x = wx[deg][31:0];
        res.y = wy[deg][31:0];
        res.z = wz[deg][31:0];
        res.in_range = 1'b1;
        return res;
    endfunction

    // Track register writes and accepted input items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg   <= 3;
            knot_cnt_reg <= 9;
        end else begin
            if (cfg_we && cfg_index == bspe_pkg::REG_DEGREE) degree_reg <= cfg_data & 6'd7;
            if (cfg_we && cfg_index == bspe_pkg::REG_KNOTS) knot_cnt_reg <= cfg_data;
            if (s_valid && s_ready) begin
                case (s_func)
                    bspe_pkg::FUNC_KNOT: knot_mem[s_slot] = s_knot_value;
                    bspe_pkg::FUNC_POINT: begin
                        cx_mem[s_slot] = s_point_x;
                        cy_mem[s_slot] = s_point_y;
                        cz_mem[s_slot] = s_point_z;
                    end
                    bspe_pkg::FUNC_EVAL: point_q.push_back(curve_point(s_param_u));
                    default: ;
                endcase
            end
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge aclk) begin
        curve_pt_t want;
        if (aresetn && m_valid && m_ready) begin
            if (point_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h in_range=%b", $time,
                         m_curve_x, m_curve_y, m_curve_z, m_in_range);
                fail_count++;
            end else begin
                want = point_q.pop_front();
                points_checked++;
                if (!want.in_range) points_outside++;
                if (m_curve_x !== want.x || m_curve_y !== want.y ||
                    m_curve_z !== want.z || m_in_range !== want.in_range) begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h in_range=%b", $time,
                             want.x, want.y, want.z, want.in_range);
                    $display("%0t:          actual   x=%h y=%h z=%h in_range=%b", $time,
                             m_curve_x, m_curve_y, m_curve_z, m_in_range);
                    fail_count++;
                end
            end
        end
        points_waiting = point_q.size();
    end

    initial begin
        fail_count = 0;
        points_waiting = 0;
        points_checked = 0;
        points_outside = 0;
    end

endmodule

// ----- tb/sv/tb_bspline_curve_point_eval_top.sv -----
// Testbench top for the B-spline curve point evaluator: drives stimulus and gives the verdict.
// Depends on bspe_pkg, bspline_curve_point_eval_top and bspe_result_checker.
module tb_bspline_curve_point_eval_top;

    localparam logic [1:0] FUNC_NONE  = 2'd3;
    localparam logic [1:0] REG_SPARE  = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint     CYCLE_LIMIT = 8000000;

    // Idling modes of the two channels.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [5:0]         cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [4:0]         s_slot;
    logic signed [31:0] s_knot_value, s_point_x, s_point_y, s_point_z, s_param_u;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_curve_x, m_curve_y, m_curve_z;
    logic               m_in_range;
    int                 fail_count, points_waiting, points_checked, points_outside;
    idle_mode_t         idle_mode;
    longint             cycle_count;
    longint             knot_copy [32];
    int                 cur_kc;
    int                 cur_deg;

    // Register settings of the random phases.
    logic [5:0] deg_val [12] = '{6'd3, 6'd1, 6'd7, 6'd0, 6'd10, 6'd7,
                                 6'd5, 6'd57, 6'd4, 6'd6, 6'd3, 6'd2};
    logic [5:0] kc_val [12]  = '{6'd9, 6'd32, 6'd32, 6'd10, 6'd40, 6'd63,
                                 6'd20, 6'd32, 6'd2, 6'd31, 6'd0, 6'd12};

    bspline_curve_point_eval_top uut (.*);

    bspe_result_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver side: ready stalls at random in the stalling modes.
    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= ($urandom_range(99) >= 69);
            IDLE_BOTH:     m_ready <= ($urandom_range(99) >= 17);
            default:       m_ready <= 1'b1;
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item and hold it until it is accepted.
    task automatic send_item(logic [1:0] func, logic [4:0] slot, logic signed [31:0] a,
                             logic signed [31:0] b, logic signed [31:0] c);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SENDER && $urandom_range(99) < 69) gap = $urandom_range(1, 5);
        if (idle_mode == IDLE_BOTH && $urandom_range(99) < 17) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_slot       <= slot;
        s_knot_value <= a;
        s_point_x    <= a;
        s_point_y    <= b;
        s_point_z    <= c;
        s_param_u    <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == bspe_pkg::FUNC_KNOT) knot_copy[slot] = a;
    endtask

    // Stop sending and wait until the block is idle and every result is delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (points_waiting != 0 || !s_ready) @(posedge aclk);
    endtask

    // Let the block drain, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == bspe_pkg::REG_DEGREE) cur_deg = val & 6'd7;
        if (idx == bspe_pkg::REG_KNOTS) cur_kc = (val > 32) ? 32 : val;
    endtask

    // Load all knots: sorted, sorted with repeats, or scrambled.
    task automatic load_knots(int shape);
        longint v;
        v = longint'($signed($urandom)) >>> 2;
        for (int i = 0; i < 32; i++) begin
            case (shape)
                0: v += $urandom_range(1, 1 << $urandom_range(4, 22));
                1: v += ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 200000);
                default: v = longint'($signed($urandom));
            endcase
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            send_item(bspe_pkg::FUNC_KNOT, i[4:0], v[31:0], $urandom, $urandom);
        end
    endtask

    // Pick a parameter mostly inside the searchable span.
    function automatic logic [31:0] pick_u();
        int     k;
        longint lo, hi;
        k = $urandom_range(31);
        if (cur_kc - cur_deg - 2 > cur_deg) k = $urandom_range(cur_deg, cur_kc - cur_deg - 2);
        lo = knot_copy[k];
        hi = (k < 31) ? knot_copy[k+1] : lo;
        case ($urandom_range(9))
            0: return $urandom;
            1: return lo[31:0];
            default: return (hi > lo) ? 32'(lo + ({$urandom, $urandom} % (hi - lo))) : lo[31:0];
        endcase
    endfunction

    initial begin
        int shape;
        cycle_count = 0;
        idle_mode = IDLE_NONE;
        cur_deg = 3;
        cur_kc = 9;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bspe_pkg::REG_DEGREE;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_func <= bspe_pkg::FUNC_KNOT;
        s_slot <= '0;
        s_knot_value <= '0;
        s_point_x <= '0;
        s_point_y <= '0;
        s_point_z <= '0;
        s_param_u <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every knot and control point entry so no evaluation reads an unwritten one.
        for (int i = 0; i < 32; i++) begin
            send_item(bspe_pkg::FUNC_KNOT, i[4:0], 32'(i * 65536), $urandom, $urandom);
            send_item(bspe_pkg::FUNC_POINT, i[4:0], $urandom, $urandom, $urandom);
        end

        // Directed: extremes, equal knots, unsorted knots, ignored codes.
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0003_8000, '0, '0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'h8000_0000, '0, '0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'h7fff_ffff, '0, '0);
        send_item(bspe_pkg::FUNC_POINT, 5'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_item(bspe_pkg::FUNC_POINT, 5'd4, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0004_4000, '0, '0);
        send_item(bspe_pkg::FUNC_KNOT, 5'd5, 32'sh0004_0000, '0, '0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0004_0000, '0, '0);
        send_item(bspe_pkg::FUNC_KNOT, 5'd2, 32'sh0007_0000, '0, '0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0004_2000, '0, '0);
        send_item(FUNC_NONE, 5'd31, $urandom, $urandom, $urandom);
        send_item(bspe_pkg::FUNC_EVAL, 5'd31, 32'sh0003_0000, '0, '0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0006_0000, '0, '0);
        write_reg(REG_SPARE, 6'd63);
        write_reg(REG_UNUSED, 6'd0);
        send_item(bspe_pkg::FUNC_EVAL, 5'd0, 32'sh0003_1000, '0, '0);

        // Random phases over register settings and idling modes.
        for (int p = 0; p < 12; p++) begin
            write_reg(bspe_pkg::REG_DEGREE, deg_val[p]);
            write_reg(bspe_pkg::REG_KNOTS, kc_val[p]);
            idle_mode = idle_mode_t'(p % 4);
            shape = (p % 5 == 3) ? 2 : ((p % 3 == 1) ? 1 : 0);
            load_knots(shape);
            for (int i = 0; i < 8; i++)
                send_item(bspe_pkg::FUNC_POINT, 5'($urandom), $urandom, $urandom, $urandom);
            for (int i = 0; i < 80; i++) begin
                // Now and then hold off until the block has delivered everything.
                if (p == 5 && i % 10 == 0) begin
                    wait_drained();
                end
                if ($urandom_range(19) == 0)
                    send_item(2'($urandom), 5'($urandom), $urandom, $urandom, $urandom);
                else
                    send_item(bspe_pkg::FUNC_EVAL, 5'($urandom), pick_u(), $urandom, $urandom);
            end
        end

        // Drain.
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Checked %0d curve points (%0d outside the span range) over 12 settings",
                 points_checked, points_outside);
        $display("of degree and knot count, with sender and receiver idling.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
